>>> rtl/core/ffea_pkg.sv
// Shared types, codes and defaults for the first-fit extent allocator.
package ffea_pkg;

  localparam int FreeExtentsDef = 16;
  localparam int UsedBlocksDef  = 64;
  localparam int HeaderBytesDef = 12;
  localparam int AlignBytesDef  = 8;

  localparam int GuardBytes  = 4;
  localparam int MaxSearches = 4;
  // Wide enough for rounded sizes and heap growth beyond 32 bits.
  localparam int XW = 35;
  localparam logic [XW-1:0] GrowMin  = 35'h0_0010_0000;
  localparam logic [XW-1:0] PageMask = 35'h0_0000_0FFF;
  localparam logic [XW-1:0] AddrMax  = 35'h0_FFFF_FFFF;

  localparam logic [31:0] HeapBaseRst  = 32'h0010_0000;
  localparam logic [31:0] HeapLimitRst = 32'h0030_0000;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeapBase  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeapLimit = 2'd1;

  localparam logic [1:0] CmdAlloc = 2'd0;
  localparam logic [1:0] CmdFree  = 2'd1;
  localparam logic [1:0] CmdQuery = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNull    = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StUnknown = 2'd3;

  typedef enum logic [4:0] {
    S_RELOAD, S_IDLE, S_RND, S_SLOT, S_FIT_RD, S_FIT_CHK, S_GROW,
    S_RM_RD, S_RM_WR, S_IN_RD, S_IN_CHK, S_IN_PREV, S_IN_PCHK, S_IN_DEC,
    S_SH_RD, S_SH_WR, S_IN_DONE, S_BF_RD, S_BF_CHK, S_ST_RD, S_ST_CHK, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] user_address;
    logic        has_space;
    logic [31:0] free_bytes;
    logic [31:0] largest_free;
    logic [31:0] total_bytes;
  } res_t;

endpackage

>>> rtl/core/ffea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ffea_ctrl.sv
// Sequencer: extent and block tables in RAM, read-modify-write per request.
module ffea_ctrl #(
  parameter int FREE_EXTENTS = ffea_pkg::FreeExtentsDef,
  parameter int USED_BLOCKS  = ffea_pkg::UsedBlocksDef,
  parameter int HEADER_BYTES = ffea_pkg::HeaderBytesDef,
  parameter int ALIGN_BYTES  = ffea_pkg::AlignBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [31:0]                  size_i,
  input  logic [31:0]                  address_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output ffea_pkg::res_t               res_o
);
  import ffea_pkg::*;

  localparam int EIW = $clog2(FREE_EXTENTS);
  localparam int ECW = $clog2(FREE_EXTENTS + 1);
  localparam int BIW = $clog2(USED_BLOCKS);
  localparam logic [XW-1:0] Hdr   = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] Split = XW'(HEADER_BYTES + 2 * ALIGN_BYTES);
  // ALIGN_BYTES must be a power of two (not enforced here): rounding up is an add and a mask
  localparam logic [XW-1:0] AlnMask = XW'(ALIGN_BYTES - 1);

  state_e state_q, state_d;
  logic [31:0] base_q, base_d, limit_q, limit_d, top_q, top_d;
  logic [ECW-1:0] cnt_q, cnt_d, i_q, i_d, p_q, p_d;
  logic [USED_BLOCKS-1:0] valid_q, valid_d;
  logic [1:0] cmd_q, cmd_d, status_q, status_d;
  logic [31:0] hdr_q, hdr_d, uaddr_q, uaddr_d, sum_q, sum_d, lrg_q, lrg_d;
  logic [XW-1:0] total_q, total_d, rx_q, rx_d, grow_q, grow_d;
  logic pass_q, pass_d, has_q, has_d;
  logic [BIW-1:0] slot_q, slot_d;
  logic [2:0] att_q, att_d;
  logic [31:0] ins_s_q, ins_s_d, ins_l_q, ins_l_d;
  logic [31:0] nxt_s_q, nxt_s_d, nxt_l_q, nxt_l_d, prv_s_q, prv_s_d, prv_l_q, prv_l_d;
  logic nxt_v_q, nxt_v_d, prv_v_q, prv_v_d;
  logic rm_ins_q, rm_ins_d, ins_free_q, ins_free_d, ins_ok_q, ins_ok_d;

  // RAM ports
  logic e_we, e_re, b_we, b_re;
  logic [EIW-1:0] e_waddr, e_raddr;
  logic [BIW-1:0] b_waddr, b_raddr;
  logic [63:0] e_wdata, e_rdata, b_wdata, b_rdata;

  ffea_ram #(.WIDTH(64), .DEPTH(FREE_EXTENTS)) u_ext_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  ffea_ram #(.WIDTH(64), .DEPTH(USED_BLOCKS)) u_blk_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .re_i(b_re), .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  // shared conditions
  logic [31:0] e_start, e_len, b_start, b_len;
  logic [XW-1:0] rounded, gmax, grow_c, top_sum;
  logic load_ok, fit_hit, do_split, grow_ovf, prev_adj, next_adj, last_slot;
  logic free_bad, cfg_reload;
  logic [32:0] sum_ext;

  assign e_start = e_rdata[63:32];
  assign e_len   = e_rdata[31:0];
  assign b_start = b_rdata[63:32];
  assign b_len   = b_rdata[31:0];
  assign load_ok = (limit_q > base_q) && ((limit_q - base_q) >= 32'(HEADER_BYTES));
  assign fit_hit  = {3'b0, e_len} >= total_q;
  assign do_split = {3'b0, e_len} >= (total_q + Split);
  assign rounded  = (rx_q + AlnMask) & ~AlnMask;
  assign gmax     = (total_q < GrowMin) ? GrowMin : total_q;
  assign grow_c   = (gmax + PageMask) & ~PageMask;
  assign top_sum  = {3'b0, top_q} + grow_c;
  assign grow_ovf = top_sum > AddrMax;
  assign prev_adj = prv_v_q && (({1'b0, prv_s_q} + {1'b0, prv_l_q}) == {1'b0, ins_s_q});
  assign next_adj = nxt_v_q && (({1'b0, ins_s_q} + {1'b0, ins_l_q}) == {1'b0, nxt_s_q});
  assign last_slot = slot_q == BIW'(USED_BLOCKS - 1);
  assign free_bad  = (address_i < 32'(HEADER_BYTES)) ||
                     ((address_i - 32'(HEADER_BYTES)) < base_q);
  assign cfg_reload = (cfg_index_i == CfgHeapBase) || (cfg_index_i == CfgHeapLimit);
  assign sum_ext   = {1'b0, sum_q} + {1'b0, e_len - 32'(HEADER_BYTES)};

  assign cfg_ready_o = state_q == S_IDLE;
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign res_valid_o = state_q == S_DONE;

  always_comb begin
    res_o.status       = status_q;
    res_o.user_address = uaddr_q;
    res_o.has_space    = has_q;
    res_o.free_bytes   = sum_q;
    res_o.largest_free = lrg_q;
    res_o.total_bytes  = (top_q > base_q) ? top_q - base_q : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_RELOAD: state_d = S_IDLE;
      S_IDLE: begin
        if (cfg_valid_i) begin
          if (cfg_reload) state_d = S_RELOAD;
        end else if (in_valid_i) begin
          case (command_i)
            CmdAlloc: state_d = (size_i == '0 || cnt_q == '0) ? S_ST_RD : S_RND;
            CmdFree:  state_d = free_bad ? S_ST_RD : S_BF_RD;
            CmdQuery: state_d = S_RND;
            default:  state_d = S_ST_RD;
          endcase
        end
      end
      S_RND: begin
        if (cmd_q == CmdQuery) state_d = S_ST_RD;
        else if (!pass_q)      state_d = S_RND;
        else                   state_d = S_SLOT;
      end
      S_SLOT: begin
        if (!valid_q[slot_q]) state_d = S_FIT_RD;
        else if (last_slot)   state_d = S_ST_RD;
      end
      S_FIT_RD:  state_d = (i_q == cnt_q) ? S_GROW : S_FIT_CHK;
      S_FIT_CHK: begin
        if (!fit_hit)      state_d = S_FIT_RD;
        else if (do_split) state_d = S_ST_RD;
        else               state_d = S_RM_RD;
      end
      S_GROW: state_d = grow_ovf ? S_ST_RD : S_IN_RD;
      S_RM_RD: begin
        if ((ECW + 1)'(i_q) + 1'b1 >= (ECW + 1)'(cnt_q)) begin
          state_d = rm_ins_q ? S_IN_DONE : S_ST_RD;
        end else begin
          state_d = S_RM_WR;
        end
      end
      S_RM_WR:   state_d = S_RM_RD;
      S_IN_RD:   state_d = (p_q == cnt_q) ? S_IN_PREV : S_IN_CHK;
      S_IN_CHK:  state_d = (e_start < ins_s_q) ? S_IN_RD : S_IN_PREV;
      S_IN_PREV: state_d = (p_q != '0) ? S_IN_PCHK : S_IN_DEC;
      S_IN_PCHK: state_d = S_IN_DEC;
      S_IN_DEC: begin
        if (prev_adj)                          state_d = next_adj ? S_RM_RD : S_IN_DONE;
        else if (next_adj)                     state_d = S_IN_DONE;
        else if (cnt_q == ECW'(FREE_EXTENTS))  state_d = S_IN_DONE;
        else                                   state_d = S_SH_RD;
      end
      S_SH_RD: state_d = (i_q == p_q) ? S_IN_DONE : S_SH_WR;
      S_SH_WR: state_d = S_SH_RD;
      S_IN_DONE: begin
        if (ins_free_q || !ins_ok_q)               state_d = S_ST_RD;
        else if (att_q == 3'(MaxSearches - 1))     state_d = S_ST_RD;
        else                                       state_d = S_FIT_RD;
      end
      S_BF_RD: begin
        if (valid_q[slot_q]) state_d = S_BF_CHK;
        else if (last_slot)  state_d = S_ST_RD;
      end
      S_BF_CHK: begin
        if (b_start == hdr_q) state_d = S_IN_RD;
        else if (last_slot)   state_d = S_ST_RD;
        else                  state_d = S_BF_RD;
      end
      S_ST_RD:  state_d = (i_q == cnt_q) ? S_DONE : S_ST_CHK;
      S_ST_CHK: state_d = S_ST_RD;
      S_DONE:   if (res_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    base_d = base_q; limit_d = limit_q; top_d = top_q; cnt_d = cnt_q;
    i_d = i_q; p_d = p_q; valid_d = valid_q; cmd_d = cmd_q; status_d = status_q;
    hdr_d = hdr_q; uaddr_d = uaddr_q; sum_d = sum_q; lrg_d = lrg_q; total_d = total_q;
    rx_d = rx_q; grow_d = grow_q;
    pass_d = pass_q; has_d = has_q; slot_d = slot_q; att_d = att_q;
    ins_s_d = ins_s_q; ins_l_d = ins_l_q; nxt_s_d = nxt_s_q; nxt_l_d = nxt_l_q;
    prv_s_d = prv_s_q; prv_l_d = prv_l_q; nxt_v_d = nxt_v_q; prv_v_d = prv_v_q;
    rm_ins_d = rm_ins_q; ins_free_d = ins_free_q; ins_ok_d = ins_ok_q;
    e_we = 1'b0; e_re = 1'b0; b_we = 1'b0; b_re = 1'b0;
    e_waddr = i_q[EIW-1:0]; e_raddr = i_q[EIW-1:0]; e_wdata = e_rdata;
    b_waddr = slot_q; b_raddr = slot_q; b_wdata = '0;

    unique case (state_q)
      S_RELOAD: begin
        e_waddr = '0;
        e_wdata = {base_q, limit_q - base_q};
        e_we    = load_ok;
        cnt_d   = load_ok ? ECW'(1) : '0;
        top_d   = limit_q;
        valid_d = '0;
      end
      S_IDLE: begin
        if (cfg_valid_i) begin
          if (cfg_index_i == CfgHeapBase)  base_d  = cfg_data_i;
          if (cfg_index_i == CfgHeapLimit) limit_d = cfg_data_i;
        end else if (in_valid_i) begin
          cmd_d = command_i; hdr_d = address_i - 32'(HEADER_BYTES);
          status_d = (command_i == CmdQuery) ? StOk : StNull;
          uaddr_d = '0; has_d = 1'b0; sum_d = '0; lrg_d = '0; i_d = '0; slot_d = '0;
          rx_d = {3'b0, size_i};
          pass_d = 1'b0;
        end
      end
      S_RND: begin
        // allocate rounds twice (size, then size plus guard); query once
        if (cmd_q == CmdQuery || pass_q) begin
          total_d = rounded + Hdr;
        end else begin
          rx_d = rounded + XW'(GuardBytes);
          pass_d = 1'b1;
        end
        i_d = '0; slot_d = '0; att_d = '0;
      end
      S_SLOT: begin
        if (valid_q[slot_q]) begin
          if (last_slot) status_d = StFull;
          else           slot_d = slot_q + 1'b1;
        end
      end
      S_FIT_RD: e_re = i_q != cnt_q;
      S_FIT_CHK: begin
        if (fit_hit) begin
          b_we = 1'b1;
          b_wdata = {e_start, do_split ? total_q[31:0] : e_len};
          valid_d[slot_q] = 1'b1;
          status_d = StOk;
          uaddr_d = e_start + 32'(HEADER_BYTES);
          rm_ins_d = 1'b0;
          if (do_split) begin
            e_we = 1'b1;
            e_wdata = {e_start + total_q[31:0], e_len - total_q[31:0]};
            i_d = '0;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_GROW: begin
        i_d = '0;
        ins_s_d = top_q; ins_l_d = grow_c[31:0]; grow_d = grow_c;
        ins_free_d = 1'b0; p_d = '0;
      end
      S_RM_RD: begin
        if ((ECW + 1)'(i_q) + 1'b1 >= (ECW + 1)'(cnt_q)) begin
          cnt_d = cnt_q - 1'b1;
          ins_ok_d = 1'b1;
          if (!rm_ins_q) i_d = '0;
        end else begin
          e_re = 1'b1;
          e_raddr = EIW'(i_q + 1'b1);
        end
      end
      S_RM_WR: begin
        e_we = 1'b1; i_d = i_q + 1'b1;
      end
      S_IN_RD: begin
        e_raddr = p_q[EIW-1:0];
        e_re = p_q != cnt_q;
        if (p_q == cnt_q) nxt_v_d = 1'b0;
      end
      S_IN_CHK: begin
        if (e_start < ins_s_q) begin
          p_d = p_q + 1'b1;
        end else begin
          nxt_s_d = e_start; nxt_l_d = e_len; nxt_v_d = 1'b1;
        end
      end
      S_IN_PREV: begin
        e_raddr = EIW'(p_q - 1'b1);
        e_re = p_q != '0;
        prv_v_d = 1'b0;
      end
      S_IN_PCHK: begin
        prv_s_d = e_start; prv_l_d = e_len; prv_v_d = 1'b1;
      end
      S_IN_DEC: begin
        ins_ok_d = 1'b1;
        if (prev_adj) begin
          e_we = 1'b1;
          e_waddr = EIW'(p_q - 1'b1);
          e_wdata = {prv_s_q, prv_l_q + ins_l_q + (next_adj ? nxt_l_q : 32'd0)};
          if (next_adj) begin
            i_d = p_q; rm_ins_d = 1'b1;
          end
        end else if (next_adj) begin
          e_we = 1'b1;
          e_waddr = p_q[EIW-1:0];
          e_wdata = {ins_s_q, nxt_l_q + ins_l_q};
        end else if (cnt_q == ECW'(FREE_EXTENTS)) begin
          ins_ok_d = 1'b0;
        end else begin
          i_d = cnt_q;
        end
      end
      S_SH_RD: begin
        if (i_q == p_q) begin
          e_we = 1'b1;
          e_wdata = {ins_s_q, ins_l_q};
          cnt_d = cnt_q + 1'b1;
        end else begin
          e_re = 1'b1;
          e_raddr = EIW'(i_q - 1'b1);
        end
      end
      S_SH_WR: begin
        e_we = 1'b1; i_d = i_q - 1'b1;
      end
      S_IN_DONE: begin
        i_d = '0;
        if (ins_free_q) begin
          if (ins_ok_q) begin
            valid_d[slot_q] = 1'b0;
            status_d = StOk;
          end else begin
            status_d = StFull;
          end
        end else if (!ins_ok_q) begin
          status_d = StFull;
        end else begin
          top_d = top_q + grow_q[31:0];
          att_d = att_q + 1'b1;
        end
      end
      S_BF_RD: begin
        b_re = valid_q[slot_q];
        if (!valid_q[slot_q]) begin
          if (last_slot) status_d = StUnknown;
          else           slot_d = slot_q + 1'b1;
        end
      end
      S_BF_CHK: begin
        if (b_start == hdr_q) begin
          ins_s_d = hdr_q; ins_l_d = b_len; ins_free_d = 1'b1; p_d = '0;
        end else if (last_slot) begin
          status_d = StUnknown;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_ST_RD: e_re = i_q != cnt_q;
      S_ST_CHK: begin
        if (e_len > 32'(HEADER_BYTES)) begin
          sum_d = sum_ext[32] ? '1 : sum_ext[31:0];
          if (e_len - 32'(HEADER_BYTES) > lrg_q) lrg_d = e_len - 32'(HEADER_BYTES);
        end
        if (cmd_q == CmdQuery && fit_hit) has_d = 1'b1;
        i_d = i_q + 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RELOAD;
      base_q  <= HeapBaseRst;
      limit_q <= HeapLimitRst;
      top_q   <= HeapLimitRst;
      cnt_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      limit_q <= limit_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; p_q <= p_d; cmd_q <= cmd_d; status_q <= status_d;
    hdr_q <= hdr_d; uaddr_q <= uaddr_d; sum_q <= sum_d; lrg_q <= lrg_d;
    total_q <= total_d; rx_q <= rx_d; grow_q <= grow_d;
    pass_q <= pass_d; has_q <= has_d;
    slot_q <= slot_d; att_q <= att_d; ins_s_q <= ins_s_d; ins_l_q <= ins_l_d;
    nxt_s_q <= nxt_s_d; nxt_l_q <= nxt_l_d; prv_s_q <= prv_s_d; prv_l_q <= prv_l_d;
    nxt_v_q <= nxt_v_d; prv_v_q <= prv_v_d; rm_ins_q <= rm_ins_d;
    ins_free_q <= ins_free_d; ins_ok_q <= ins_ok_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ECW'(FREE_EXTENTS))
    else $error("extent count above table size");

  a_reload_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELOAD && load_ok) |=> (cnt_q == ECW'(1) && valid_q == '0))
    else $error("reload did not leave a single extent");

  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmd_q == CmdAlloc && status_q == StOk) |-> valid_q[slot_q])
    else $error("allocated block not marked in use");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result changed while waiting");

endmodule

>>> rtl/core/first_fit_extent_allocator_top.sv
// Top level: allocator sequencer plus the result output register.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------
//  cfg     | in  | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  in      | in  | in_valid_i/ready_o    | command_i, size_i, address_i
//  out     | out | out_valid_o/ready_i   | status_o, user_address_o, has_space_o,
//          |     |                       | free_bytes_o, largest_free_o, total_bytes_o
//
// One request at a time. Allocate: rounds the size twice, probes block slots, then
// scans, moves and sums extents. Free: searches the block slots, then the insert
// and the summary scan. Query: a rounding, then a scan of every extent.
// After reset or a heap register write, a reload state rewrites extent entry 0.
// Results wait in the output register; the next request is taken meanwhile.
module first_fit_extent_allocator_top #(
  parameter int FREE_EXTENTS = ffea_pkg::FreeExtentsDef,
  parameter int USED_BLOCKS  = ffea_pkg::UsedBlocksDef,
  parameter int HEADER_BYTES = ffea_pkg::HeaderBytesDef,
  parameter int ALIGN_BYTES  = ffea_pkg::AlignBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ffea_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [31:0]                  size_i,
  input  logic [31:0]                  address_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   status_o,
  output logic [31:0]                  user_address_o,
  output logic                         has_space_o,
  output logic [31:0]                  free_bytes_o,
  output logic [31:0]                  largest_free_o,
  output logic [31:0]                  total_bytes_o
);
  import ffea_pkg::*;

  res_t res, out_q, out_d;
  logic res_valid, res_ready;
  logic out_valid_q, out_valid_d;

  ffea_ctrl #(
    .FREE_EXTENTS(FREE_EXTENTS), .USED_BLOCKS(USED_BLOCKS),
    .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) u_ctrl (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .command_i, .size_i, .address_i,
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_d = res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign user_address_o = out_q.user_address;
  assign has_space_o    = out_q.has_space;
  assign free_bytes_o   = out_q.free_bytes;
  assign largest_free_o = out_q.largest_free;
  assign total_bytes_o  = out_q.total_bytes;

endmodule

>>> bench/first_fit_extent_allocator_top_tb.sv
// Testbench for the first-fit extent allocator: directed and random requests checked against a predictor.
module first_fit_extent_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffea_pkg::*;

  localparam int NExt = FreeExtentsDef;
  localparam int NBlk = UsedBlocksDef;
  localparam logic [63:0] Hdr = 64'(HeaderBytesDef);
  localparam logic [63:0] Aln = 64'(AlignBytesDef);
  localparam logic [1:0] CmdUnused = 2'd3;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] command_i;
  logic [31:0] size_i, address_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] status_o;
  logic [31:0] user_address_o;
  logic has_space_o;
  logic [31:0] free_bytes_o, largest_free_o, total_bytes_o;

  first_fit_extent_allocator_top i_dut (.*);

  always begin
    clk_i = 1'b0;
    #4ns;
    clk_i = 1'b1;
    #4ns;
  end

  // predictor state
  logic [31:0] heap_base_q, heap_limit_q, heap_top_q;
  logic [31:0] ext_start[NExt], ext_len[NExt];
  int ext_cnt;
  logic [31:0] blk_start[NBlk], blk_len[NBlk];
  bit blk_live[NBlk];

  res_t pending_res[$];
  logic [31:0] live_addrs[$];
  int errors = 0;
  int in_idle_pct = 0, out_idle_pct = 0;

  function automatic logic [63:0] round_to_align(logic [63:0] x);
    return (x + Aln - 1) & ~(Aln - 1);
  endfunction

  function automatic void heap_reload();
    ext_cnt = 0;
    if (heap_limit_q > heap_base_q && 64'(heap_limit_q - heap_base_q) >= Hdr) begin
      ext_start[0] = heap_base_q;
      ext_len[0] = heap_limit_q - heap_base_q;
      ext_cnt = 1;
    end
    heap_top_q = heap_limit_q;
    for (int i = 0; i < NBlk; i++) begin
      blk_start[i] = '0;
      blk_len[i] = '0;
      blk_live[i] = 1'b0;
    end
  endfunction

  function automatic void ext_remove(int i);
    for (int k = i; k + 1 < ext_cnt; k++) begin
      ext_start[k] = ext_start[k+1];
      ext_len[k] = ext_len[k+1];
    end
    ext_cnt--;
  endfunction

  function automatic bit ext_insert(logic [31:0] s, logic [31:0] l);
    int p = 0;
    bit prev_adj, next_adj;
    while (p < ext_cnt && ext_start[p] < s) p++;
    prev_adj = p > 0 && (64'(ext_start[p-1]) + 64'(ext_len[p-1]) == 64'(s));
    next_adj = p < ext_cnt && (64'(s) + 64'(l) == 64'(ext_start[p]));
    if (prev_adj) begin
      ext_len[p-1] += l;
      if (next_adj) begin
        ext_len[p-1] += ext_len[p];
        ext_remove(p);
      end
      return 1'b1;
    end
    if (next_adj) begin
      ext_start[p] = s;
      ext_len[p] += l;
      return 1'b1;
    end
    if (ext_cnt >= NExt) return 1'b0;
    for (int k = ext_cnt; k > p; k--) begin
      ext_start[k] = ext_start[k-1];
      ext_len[k] = ext_len[k-1];
    end
    ext_start[p] = s;
    ext_len[p] = l;
    ext_cnt++;
    return 1'b1;
  endfunction

  function automatic void alloc_model(logic [31:0] size, output logic [1:0] st,
                                      output logic [31:0] ua);
    int slot;
    logic [63:0] need, grow;
    logic [31:0] hdr, blen;
    st = StNull;
    ua = '0;
    if (size == 0 || ext_cnt == 0) return;
    for (slot = 0; slot < NBlk && blk_live[slot]; slot++);
    if (slot >= NBlk) begin
      st = StFull;
      return;
    end
    need = round_to_align(round_to_align(64'(size)) + GuardBytes) + Hdr;
    for (int a = 0; a < MaxSearches; a++) begin
      for (int i = 0; i < ext_cnt; i++) begin
        if (64'(ext_len[i]) >= need) begin
          hdr = ext_start[i];
          if (64'(ext_len[i]) >= need + Hdr + 2 * Aln) begin
            blen = need[31:0];
            ext_start[i] += blen;
            ext_len[i] -= blen;
          end else begin
            blen = ext_len[i];
            ext_remove(i);
          end
          blk_start[slot] = hdr;
          blk_len[slot] = blen;
          blk_live[slot] = 1'b1;
          st = StOk;
          ua = hdr + 32'(Hdr);
          return;
        end
      end
      grow = need < 64'(GrowMin) ? 64'(GrowMin) : need;
      grow = (grow + 64'(PageMask)) & ~64'(PageMask);
      if (64'(heap_top_q) + grow > 64'(AddrMax)) return;
      if (!ext_insert(heap_top_q, grow[31:0])) begin
        st = StFull;
        return;
      end
      heap_top_q += grow[31:0];
    end
  endfunction

  function automatic logic [1:0] free_model(logic [31:0] addr);
    logic [31:0] hdr;
    if (addr == 0 || 64'(addr) < Hdr) return StNull;
    hdr = addr - 32'(Hdr);
    if (hdr < heap_base_q) return StNull;
    for (int i = 0; i < NBlk; i++) begin
      if (blk_live[i] && blk_start[i] == hdr) begin
        if (!ext_insert(hdr, blk_len[i])) return StFull;
        blk_live[i] = 1'b0;
        return StOk;
      end
    end
    return StUnknown;
  endfunction

  function automatic res_t predict_alloc_result(logic [1:0] cmd, logic [31:0] size,
                                                logic [31:0] addr);
    res_t r;
    logic [63:0] want, sum;
    logic [31:0] u;
    r = '0;
    r.status = StNull;
    if (cmd == CmdAlloc) begin
      alloc_model(size, r.status, r.user_address);
    end else if (cmd == CmdFree) begin
      r.status = free_model(addr);
    end else if (cmd == CmdQuery) begin
      want = round_to_align(64'(size)) + Hdr;
      for (int i = 0; i < ext_cnt; i++)
        if (64'(ext_len[i]) >= want) r.has_space = 1'b1;
      r.status = StOk;
    end
    sum = '0;
    for (int i = 0; i < ext_cnt; i++) begin
      if (64'(ext_len[i]) > Hdr) begin
        u = ext_len[i] - 32'(Hdr);
        sum += 64'(u);
        if (u > r.largest_free) r.largest_free = u;
      end
    end
    r.free_bytes = sum > 64'(AddrMax) ? 32'hFFFF_FFFF : sum[31:0];
    r.total_bytes = heap_top_q > heap_base_q ? heap_top_q - heap_base_q : '0;
    return r;
  endfunction

  // one request on the input channel; caller is at a rising edge
  task automatic send_req(logic [1:0] cmd, logic [31:0] size, logic [31:0] addr);
    res_t r;
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    size_i <= size;
    address_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_alloc_result(cmd, size, addr);
    pending_res.push_back(r);
    if (cmd == CmdAlloc && r.status == StOk) live_addrs.push_back(r.user_address);
    if (cmd == CmdFree && r.status == StOk)
      foreach (live_addrs[i])
        if (live_addrs[i] == addr) begin
          live_addrs.delete(i);
          break;
        end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_heap_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgHeapBase) heap_base_q = data;
    else heap_limit_q = data;
    heap_reload();
    live_addrs.delete();
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] limit);
    write_heap_reg(CfgHeapBase, base);
    write_heap_reg(CfgHeapLimit, limit);
  endtask

  task automatic free_live(int idx);
    send_req(CmdFree, $urandom, live_addrs[idx]);
  endtask

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    out_ready_i <= ($urandom_range(0, 99) >= out_idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_res.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (user_address_o !== e.user_address) begin
          $error("user_address exp %h got %h", e.user_address, user_address_o); errors++;
        end
        if (has_space_o !== e.has_space) begin
          $error("has_space exp %0d got %0d", e.has_space, has_space_o); errors++;
        end
        if (free_bytes_o !== e.free_bytes) begin
          $error("free_bytes exp %h got %h", e.free_bytes, free_bytes_o); errors++;
        end
        if (largest_free_o !== e.largest_free) begin
          $error("largest_free exp %h got %h", e.largest_free, largest_free_o); errors++;
        end
        if (total_bytes_o !== e.total_bytes) begin
          $error("total_bytes exp %h got %h", e.total_bytes, total_bytes_o); errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(CmdAlloc, 32'd0, 32'd0);
    send_req(CmdAlloc, 32'd1, 32'd0);
    send_req(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(CmdQuery, 32'd0, 32'd0);
    send_req(CmdQuery, 32'hFFFF_FFFF, 32'd0);
    send_req(CmdAlloc, 32'hFFFF_FFFF, 32'd0);  // growth past address space
    send_req(CmdAlloc, 32'h0030_0000, 32'd0);  // needs growth
    send_req(CmdFree, 32'd0, 32'd0);
    send_req(CmdFree, 32'd0, 32'd5);
    send_req(CmdFree, 32'd0, 32'h0000_0100);    // header below base
    send_req(CmdFree, 32'd0, heap_base_q + 32'h100);  // unknown block
    send_req(CmdFree, 32'd0, 32'hFFFF_FFFF);
    free_live(0);
    free_live(0);
    send_req(CmdFree, 32'd0, heap_base_q + 32'd12);  // double free
    set_heap(32'h0010_0000, 32'h0010_0000);  // empty extent table
    send_req(CmdAlloc, 32'd16, 32'd0);
    set_heap(32'hFFF0_0000, 32'hFFF0_0100);
    send_req(CmdAlloc, 32'h1000, 32'd0);
    send_req(CmdAlloc, 32'd8, 32'd0);
    send_req(CmdAlloc, 32'hF0, 32'd0);       // does not fit the rest of the extent; growth runs past address space
  endtask

  // block table full, then a fragmented extent table
  task automatic test_tables_full();
    set_heap(HeapBaseRst, HeapLimitRst);
    for (int i = 0; i < NBlk + 1; i++) send_req(CmdAlloc, $urandom_range(1, 64), 32'd0);
    for (int i = live_addrs.size() - 2; i >= 0; i -= 2) free_live(i);
    send_req(CmdAlloc, 32'h0040_0000, 32'd0);
    while (live_addrs.size() != 0) free_live($urandom_range(0, live_addrs.size() - 1));
  endtask

  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_req(CmdAlloc, $urandom_range(1, 400), $urandom);
      else if (r < 46) send_req(CmdAlloc, $urandom_range(1, 32'h0040_0000), $urandom);
      else if (r < 78 && live_addrs.size() != 0)
        free_live($urandom_range(0, live_addrs.size() - 1));
      else if (r < 88) send_req(CmdQuery, $urandom_range(0, 32'h0030_0000), $urandom);
      else if (r < 92) send_req(CmdQuery, $urandom, $urandom);
      else if (r < 96) send_req(CmdFree, $urandom, $urandom);
      else if (r < 98) send_req(CmdAlloc, $urandom, $urandom);
      else send_req(CmdUnused, $urandom, $urandom);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    size_i = '0;
    address_i = '0;
    heap_base_q = HeapBaseRst;
    heap_limit_q = HeapLimitRst;
    heap_reload();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    in_idle_pct = 14;
    out_idle_pct = 50;
    test_directed();
    test_tables_full();
    set_heap(32'h0, 32'hFFFF_FFFF);
    test_random(60);
    set_heap(32'hFFFF_FFFF, 32'h0);
    test_random(20);
    set_heap(32'h0010_0000, 32'h0010_000B);  // shorter than one header
    test_random(20);
    set_heap(HeapBaseRst, HeapLimitRst);
    test_random(300);
    in_idle_pct = 50;
    out_idle_pct = 14;
    set_heap($urandom_range(1, 32'h0100_0000), $urandom_range(32'h0100_1000, 32'h0200_0000));
    test_random(300);
    in_idle_pct = 0;
    out_idle_pct = 0;
    set_heap(HeapBaseRst, HeapLimitRst);
    test_random(300);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("[first_fit_extent_allocator_top] OK");
    end else begin
      $display("[first_fit_extent_allocator_top] ERROR");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("[first_fit_extent_allocator_top] ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ffea_pkg.sv
rtl/core/ffea_ram.sv
rtl/core/ffea_ctrl.sv
rtl/core/first_fit_extent_allocator_top.sv
bench/first_fit_extent_allocator_top_tb.sv
